[design/kdes_pkg.sv]
// Shared constants and types for the key debounce and encoder scanner.
`default_nettype none
package kdes_pkg;

  localparam int KEY_COUNT = 5;   // debounce lanes, 1..16
  localparam int KEY_PINS  = 5;   // key pin and event mask width
  localparam int CNT_W     = 8;
  localparam int ENC_W     = 2;

  localparam logic [CNT_W-1:0] THR_RESET = 8'd30;
  localparam logic [CNT_W-1:0] THR_MAX   = 8'd254;

  localparam int ENC_UP_BIT   = 0;
  localparam int ENC_DOWN_BIT = 1;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic press;
    logic release_evt;
  } kdes_key_evt_t;

  typedef struct packed {
    logic step;
    logic dir;
  } kdes_enc_evt_t;

endpackage
`default_nettype wire

[design/kdes_in_if.sv]
// Request channel carrying one scan tick of raw pin levels.
`default_nettype none
interface kdes_in_if;
  import kdes_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_PINS-1:0] key_pins;
  logic [ENC_W-1:0]    encoder_pins;

  modport source (output valid, output key_pins, output encoder_pins, input ready);
  modport sink   (input valid, input key_pins, input encoder_pins, output ready);
endinterface
`default_nettype wire

[design/kdes_out_if.sv]
// Result channel carrying the key and encoder events of one scan tick.
`default_nettype none
interface kdes_out_if;
  import kdes_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_PINS-1:0] press_mask;
  logic [KEY_PINS-1:0] release_mask;
  logic                encoder_step;
  logic                encoder_direction;

  modport source (output valid, output press_mask, output release_mask,
                  output encoder_step, output encoder_direction, input ready);
  modport sink   (input valid, input press_mask, input release_mask,
                  input encoder_step, input encoder_direction, output ready);
endinterface
`default_nettype wire

[design/kdes_key_lane.sv]
// One key's debounce counter with press and release detection.
`default_nettype none
module kdes_key_lane (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic            pin,
  input  wire kdes_pkg::cnt_t  thr,
  output kdes_pkg::kdes_key_evt_t evt
);
  import kdes_pkg::*;

  cnt_t cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt         = cnt_r;
    evt.press       = 1'b0;
    evt.release_evt = 1'b0;
    if (pin) begin
      // release is reported for any nonzero count, pressed or not
      if (cnt_r != '0) begin
        evt.release_evt = 1'b1;
        cnt_nxt         = '0;
      end
    end else if (cnt_r < thr) begin
      cnt_nxt = cnt_r + cnt_t'(1);
    end else if (cnt_r == thr) begin
      evt.press = 1'b1;
      cnt_nxt   = cnt_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

[design/kdes_encoder.sv]
// Four-phase quadrature detent tracker.
`default_nettype none
module kdes_encoder (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire logic [kdes_pkg::ENC_W-1:0] pins,
  output kdes_pkg::kdes_enc_evt_t evt
);
  import kdes_pkg::*;

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_UP_FIRST   = 2'd1;
  localparam logic [1:0] PH_DOWN_FIRST = 2'd2;
  localparam logic [1:0] PH_WAIT       = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic       up_open, down_open;

  assign up_open   = pins[ENC_UP_BIT];
  assign down_open = pins[ENC_DOWN_BIT];

  always_comb begin
    phase_nxt = phase_r;
    evt.step  = 1'b0;
    evt.dir   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (!up_open) phase_nxt = PH_UP_FIRST;
        else if (!down_open) phase_nxt = PH_DOWN_FIRST;
      end
      PH_UP_FIRST: begin
        if (!down_open) begin
          evt.step  = 1'b1;
          evt.dir   = 1'b1;
          phase_nxt = PH_WAIT;
        end
        // leading contact open wins over the wait phase
        if (up_open) phase_nxt = PH_IDLE;
      end
      PH_DOWN_FIRST: begin
        if (!up_open) begin
          evt.step  = 1'b1;
          phase_nxt = PH_WAIT;
        end
        if (down_open) phase_nxt = PH_IDLE;
      end
      default: begin
        if (up_open && down_open) phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (advance) begin
      phase_r <= phase_nxt;
    end
  end
endmodule
`default_nettype wire

[design/key_debounce_and_encoder_scan.sv]
// Top level: debounce lanes, encoder tracker and the result register.
//
// Takes one scan tick per clock cycle when not stalled and returns exactly one
// result per tick, in the next cycle. Every key has its own debounce
// lane; all lanes and the encoder tracker update in the cycle the request is
// accepted, and their events are merged into a single output register. A new
// request is accepted whenever that register is empty or being drained in the
// same cycle, so out.ready low stalls the input only while a result waits.
// The threshold written through cfg_wdata takes effect for the next tick; a
// value of 255 behaves as 254. Keys beyond the pin width see a pressed pin and
// their events are not reported.
`default_nettype none
module key_debounce_and_encoder_scan (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  kdes_in_if.sink                          in_ch,
  kdes_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [kdes_pkg::CNT_W-1:0]  cfg_wdata
);
  import kdes_pkg::*;

  cnt_t                thr_r;
  cnt_t                thr_eff;
  logic                accept;
  logic [KEY_COUNT-1:0] lane_pin;
  kdes_key_evt_t       lane_evt [KEY_COUNT];
  kdes_enc_evt_t       enc_evt;

  logic                out_valid_r;
  logic [KEY_PINS-1:0] press_r, press_nxt;
  logic [KEY_PINS-1:0] release_r, release_nxt;
  logic                step_r;
  logic                dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign thr_eff      = (thr_r > THR_MAX) ? THR_MAX : thr_r;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;

  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
    if (i < KEY_PINS) begin : g_pin
      assign lane_pin[i] = in_ch.key_pins[i];
    end else begin : g_nopin
      assign lane_pin[i] = 1'b0;
    end

    kdes_key_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (accept),
      .pin     (lane_pin[i]),
      .thr     (thr_eff),
      .evt     (lane_evt[i])
    );
  end

  for (genvar j = 0; j < KEY_PINS; j++) begin : g_merge
    if (j < KEY_COUNT) begin : g_used
      assign press_nxt[j]   = lane_evt[j].press;
      assign release_nxt[j] = lane_evt[j].release_evt;
    end else begin : g_unused
      assign press_nxt[j]   = 1'b0;
      assign release_nxt[j] = 1'b0;
    end
  end

  kdes_encoder u_enc (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .pins    (in_ch.encoder_pins),
    .evt     (enc_evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      press_r   <= press_nxt;
      release_r <= release_nxt;
      step_r    <= enc_evt.step;
      dir_r     <= enc_evt.dir;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.press_mask        = press_r;
  assign out_ch.release_mask      = release_r;
  assign out_ch.encoder_step      = step_r;
  assign out_ch.encoder_direction = dir_r;
endmodule
`default_nettype wire

[verif/tb_key_debounce_and_encoder_scan.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the key debounce and encoder scanner.
module tb_key_debounce_and_encoder_scan;
  import kdes_pkg::*;

  localparam int WDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_UP_FIRST,
    PH_DOWN_FIRST,
    PH_WAIT
  } enc_phase_e;

  typedef struct packed {
    logic [KEY_PINS-1:0] press_mask;
    logic [KEY_PINS-1:0] rel_mask;
    logic                step;
    logic                dir;
  } scan_evt_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cnt_t cfg_wdata;

  kdes_in_if  in_ch();
  kdes_out_if out_ch();

  key_debounce_and_encoder_scan DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // scanner state as the testbench sees it
  cnt_t       key_cnt [KEY_COUNT];
  enc_phase_e enc_phase;
  cnt_t       thr_reg;
  scan_evt_t  evt_q [$];

  int err_cnt      = 0;
  int tick_cnt     = 0;
  int press_cnt    = 0;
  int rel_cnt      = 0;
  int step_cnt     = 0;
  int quiet_cycles = 0;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_scan_state();
    for (int i = 0; i < KEY_COUNT; i++) key_cnt[i] = '0;
    enc_phase = PH_IDLE;
    thr_reg   = THR_RESET;
  endfunction

  // Advance the scanner by one tick and return the events it reports.
  function automatic scan_evt_t scan_tick(input logic [KEY_PINS-1:0] keys,
                                          input logic [ENC_W-1:0] enc);
    scan_evt_t r;
    cnt_t      thr;
    logic      pin;
    logic      up_open;
    logic      down_open;
    r   = '0;
    thr = (thr_reg > THR_MAX) ? THR_MAX : thr_reg;
    for (int i = 0; i < KEY_COUNT; i++) begin
      // lanes past the pin width always see a pressed pin
      pin = (i < KEY_PINS) ? keys[i] : 1'b0;
      if (pin) begin
        if (key_cnt[i] != '0) begin
          if (i < KEY_PINS) r.rel_mask[i] = 1'b1;
          key_cnt[i] = '0;
        end
      end else if (key_cnt[i] < thr) begin
        key_cnt[i] = key_cnt[i] + 1'b1;
      end else if (key_cnt[i] == thr) begin
        if (i < KEY_PINS) r.press_mask[i] = 1'b1;
        key_cnt[i] = key_cnt[i] + 1'b1;
      end
    end
    up_open   = enc[ENC_UP_BIT];
    down_open = enc[ENC_DOWN_BIT];
    case (enc_phase)
      PH_IDLE: begin
        if (!up_open) enc_phase = PH_UP_FIRST;
        else if (!down_open) enc_phase = PH_DOWN_FIRST;
      end
      PH_UP_FIRST: begin
        if (!down_open) begin
          r.step    = 1'b1;
          r.dir     = 1'b1;
          enc_phase = PH_WAIT;
        end
        // leading contact open again wins over the wait phase
        if (up_open) enc_phase = PH_IDLE;
      end
      PH_DOWN_FIRST: begin
        if (!up_open) begin
          r.step    = 1'b1;
          r.dir     = 1'b0;
          enc_phase = PH_WAIT;
        end
        if (down_open) enc_phase = PH_IDLE;
      end
      default: begin
        if (up_open && down_open) enc_phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Result check first, then prediction for the request accepted at this edge.
  always @(posedge clk) begin
    scan_evt_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (evt_q.size() == 0) begin
          err_cnt++;
          $display({"%0t: unexpected result, expected none, ",
                    "actual press %0h release %0h step %0b dir %0b"},
                   $time, out_ch.press_mask, out_ch.release_mask,
                   out_ch.encoder_step, out_ch.encoder_direction);
        end else begin
          want = evt_q.pop_front();
          check_field("press_mask", want.press_mask, out_ch.press_mask);
          check_field("release_mask", want.rel_mask, out_ch.release_mask);
          check_field("encoder_step", want.step, out_ch.encoder_step);
          check_field("encoder_direction", want.dir, out_ch.encoder_direction);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = scan_tick(in_ch.key_pins, in_ch.encoder_pins);
        evt_q.push_back(want);
        tick_cnt++;
        press_cnt += $countones(want.press_mask);
        rel_cnt   += $countones(want.rel_mask);
        step_cnt  += want.step;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, WDOG_LIMIT, evt_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(99) < 6);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high until the next call.
  task automatic send_tick(input logic [KEY_PINS-1:0] keys, input logic [ENC_W-1:0] enc);
    int gap;
    if (tx_idle_on && $urandom_range(99) < 6) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.key_pins     <= keys;
    in_ch.encoder_pins <= enc;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_threshold(input cnt_t val);
    in_ch.valid <= 1'b0;
    while (evt_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    thr_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_release_without_press();
    send_tick('1, 2'b11);
    send_tick('0, 2'b11);
    send_tick('1, 2'b11);
  endtask

  task automatic test_encoder_phases();
    // clean turns both ways, same-tick return to idle both ways,
    // both contacts closed from idle, and an aborted turn
    logic [1:0] seq [] = '{2'b10, 2'b00, 2'b01, 2'b11,
                           2'b01, 2'b00, 2'b11,
                           2'b10, 2'b01,
                           2'b01, 2'b10,
                           2'b00, 2'b00, 2'b11,
                           2'b10, 2'b11};
    foreach (seq[i]) send_tick('1, seq[i]);
  endtask

  task automatic test_threshold_zero();
    write_threshold(8'd0);
    send_tick(5'b11110, 2'b11);
    send_tick(5'b11110, 2'b11);
    send_tick('1, 2'b11);
  endtask

  task automatic test_threshold_below_count();
    write_threshold(8'd5);
    repeat (3) send_tick(5'b11101, 2'b11);
    write_threshold(8'd1);
    send_tick(5'b11101, 2'b11);
    write_threshold(8'd10);
    send_tick(5'b11101, 2'b11);
    send_tick('1, 2'b11);
  endtask

  task automatic test_threshold_max();
    cnt_t vals [2] = '{8'd255, 8'd254};
    foreach (vals[v]) begin
      write_threshold(vals[v]);
      // key 4 held long enough to reach the ceiling, the others chatter
      repeat (257) send_tick({1'b0, 4'($urandom)}, 2'($urandom));
      send_tick('1, 2'b11);
    end
  endtask

  task automatic test_backpressure();
    write_threshold(8'd2);
    hold_req = 1'b1;
    repeat (40) send_tick(KEY_PINS'($urandom), 2'($urandom));
  endtask

  task automatic test_random_phase(input int n, input int thr, input bit idle);
    logic                lvl [KEY_PINS];
    int                  run [KEY_PINS];
    logic [1:0]          up_turn [5]   = '{2'b11, 2'b10, 2'b00, 2'b01, 2'b11};
    logic [1:0]          down_turn [5] = '{2'b11, 2'b01, 2'b00, 2'b10, 2'b11};
    int                  enc_idx;
    bit                  turn_dn;
    logic [KEY_PINS-1:0] keys;
    logic [ENC_W-1:0]    enc;
    write_threshold(cnt_t'(thr));
    tx_idle_on = idle;
    rx_idle_on = idle;
    enc_idx    = 0;
    turn_dn    = 1'b0;
    foreach (lvl[i]) begin
      lvl[i] = 1'b1;
      run[i] = 0;
    end
    repeat (n) begin
      // keys are held for runs around the threshold so presses get through
      for (int i = 0; i < KEY_PINS; i++) begin
        if (run[i] == 0) begin
          if ($urandom_range(3) != 0) lvl[i] = !lvl[i];
          run[i] = $urandom_range(1, thr + 4);
        end
        run[i]--;
        keys[i] = lvl[i];
      end
      if ($urandom_range(99) < 10) keys = KEY_PINS'($urandom);
      if ($urandom_range(99) < 70) begin
        if (enc_idx == 4) begin
          enc_idx = 0;
          turn_dn = $urandom_range(1);
        end else begin
          enc_idx++;
        end
      end
      enc = turn_dn ? down_turn[enc_idx] : up_turn[enc_idx];
      if ($urandom_range(99) < 10) enc = 2'($urandom);
      send_tick(keys, enc);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.key_pins     = '1;
    in_ch.encoder_pins = '1;
    tx_idle_on         = 1'b1;
    rx_idle_on         = 1'b1;
    hold_req           = 1'b0;
    reset_scan_state();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_release_without_press();
    test_encoder_phases();
    test_threshold_zero();
    test_threshold_below_count();
    test_threshold_max();
    test_backpressure();
    test_random_phase(120, 1, 1'b1);
    test_random_phase(120, 0, 1'b1);
    test_random_phase(120, 3, 1'b1);
    test_random_phase(300, 2, 1'b0);
    test_random_phase(120, 6, 1'b1);
    test_random_phase(120, $urandom_range(0, 8), 1'b1);
    test_random_phase(120, 20, 1'b1);
    test_random_phase(120, 4, 1'b1);

    in_ch.valid <= 1'b0;
    while (evt_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Run covered %0d scan ticks with %0d presses, %0d releases and %0d encoder steps,",
             tick_cnt, press_cnt, rel_cnt, step_cnt);
    $display("thresholds from 0 to 255, a long output stall and %0d mismatches.", err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
